// ===== sv/lbt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and texel conversion for the tiled pixel writer.
package lbt_pkg;

	localparam int MAX_DIMENSION = 1024;
	localparam int DIM_W         = $clog2(MAX_DIMENSION) + 1;
	localparam int COORD_W       = $clog2(MAX_DIMENSION);
	localparam int BLK_W         = COORD_W - 2;
	localparam int BCNT_W        = DIM_W - 2;
	localparam int PIXEL_W       = 32;
	localparam int TEXEL_W       = 16;
	localparam int INDEX_W       = 20;
	localparam int CFG_DATA_W    = DIM_W;

	localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIMENSION);

	typedef enum logic [1:0] {
		REG_FRAME_WIDTH   = 2'd0,
		REG_FRAME_HEIGHT  = 2'd1,
		REG_SOURCE_FORMAT = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		FMT_RGB565   = 1'b0,
		FMT_XRGB8888 = 1'b1
	} src_fmt_t;

	typedef struct packed {
		logic [DIM_W-1:0]  width;
		logic [DIM_W-1:0]  height;
		logic [BCNT_W-1:0] blocks_x;
		logic [BCNT_W-1:0] blocks_y;
		src_fmt_t          format;
	} cfg_t;

	typedef struct packed {
		logic [BLK_W-1:0]   col_blk;
		logic [BLK_W-1:0]   row_blk;
		logic [1:0]         col_lo;
		logic [1:0]         row_lo;
		logic               last;
		logic [PIXEL_W-1:0] pixel;
	} loc_t;

	function automatic logic [DIM_W-1:0] effective_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > DIM_MAX) begin
			r = DIM_MAX;
		end else begin
			r = v;
		end
		return r;
	endfunction

	function automatic logic [TEXEL_W-1:0] to_texel(input logic [PIXEL_W-1:0] p,
			input src_fmt_t fmt);
		logic [TEXEL_W-1:0] t;
		if (fmt == FMT_RGB565) begin
			t = p[TEXEL_W-1:0];
		end else begin
			t = {p[23:19], p[15:10], p[7:3]};
		end
		return t;
	endfunction

endpackage

// ===== sv/lbt_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for source pixels and tiled texels.
interface lbt_pixel_if
	import lbt_pkg::*;
	;
	logic               valid;
	logic               ready;
	logic [PIXEL_W-1:0] source_pixel;

	modport source (output valid, output source_pixel, input ready);
	modport sink (input valid, input source_pixel, output ready);
endinterface

interface lbt_texel_if
	import lbt_pkg::*;
	;
	logic               valid;
	logic               ready;
	logic [INDEX_W-1:0] tile_index;
	logic [TEXEL_W-1:0] texel;
	logic               frame_last;

	modport source (output valid, output tile_index, output texel, output frame_last,
		input ready);
	modport sink (input valid, input tile_index, input texel, input frame_last,
		output ready);
endinterface

// ===== sv/lbt_cfg.sv =====
`timescale 1ns / 1ps
// Configuration registers and the clamped frame geometry derived from them.
module lbt_cfg
	import lbt_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                  cfg
);

	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	src_fmt_t         format_q;
	logic [DIM_W-1:0] width_eff;
	logic [DIM_W-1:0] height_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(640);
			height_q <= DIM_W'(480);
			format_q <= FMT_RGB565;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_FRAME_WIDTH:   width_q  <= cfg_wdata[DIM_W-1:0];
				REG_FRAME_HEIGHT:  height_q <= cfg_wdata[DIM_W-1:0];
				REG_SOURCE_FORMAT: format_q <= src_fmt_t'(cfg_wdata[0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		width_eff    = effective_dim(width_q);
		height_eff   = effective_dim(height_q);
		cfg.width    = width_eff;
		cfg.height   = height_eff;
		cfg.blocks_x = width_eff[DIM_W-1:2];
		cfg.blocks_y = height_eff[DIM_W-1:2];
		cfg.format   = format_q;
	end

endmodule

// ===== sv/lbt_locate.sv =====
`timescale 1ns / 1ps
// Raster counters and the input register that keeps whole-block pixels.
module lbt_locate
	import lbt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	lbt_pixel_if.sink  pixels,
	output loc_t       loc,
	output logic       loc_valid,
	input  logic       loc_ready
);

	logic [COORD_W-1:0] col_q;
	logic [COORD_W-1:0] row_q;
	logic               valid_s1;
	loc_t               loc_s1;
	logic               accept;
	logic               keep;
	logic               last;
	logic               col_end;
	logic               row_end;
	logic [DIM_W-1:0]   kept_w;
	logic [DIM_W-1:0]   kept_h;
	logic [DIM_W-1:0]   col_x;
	logic [DIM_W-1:0]   row_x;

	assign pixels.ready = !valid_s1 || loc_ready;
	assign accept       = pixels.valid && pixels.ready;

	always_comb begin
		col_x   = DIM_W'(col_q);
		row_x   = DIM_W'(row_q);
		kept_w  = {cfg.blocks_x, 2'b00};
		kept_h  = {cfg.blocks_y, 2'b00};
		keep    = (col_x < kept_w) && (row_x < kept_h);
		last    = (col_x == kept_w - DIM_W'(1)) && (row_x == kept_h - DIM_W'(1));
		col_end = col_x >= cfg.width - DIM_W'(1);
		row_end = row_x >= cfg.height - DIM_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? '0 : row_q + COORD_W'(1);
			end else begin
				col_q <= col_q + COORD_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= keep;
		end else if (loc_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && keep) begin
			loc_s1.col_blk <= col_q[COORD_W-1:2];
			loc_s1.row_blk <= row_q[COORD_W-1:2];
			loc_s1.col_lo  <= col_q[1:0];
			loc_s1.row_lo  <= row_q[1:0];
			loc_s1.last    <= last;
			loc_s1.pixel   <= pixels.source_pixel;
		end
	end

	assign loc       = loc_s1;
	assign loc_valid = valid_s1;

	a_col_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		accept && col_end |=> col_q == '0)
		else $error("column counter did not wrap at the end of a line");

	a_col_step: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !col_end |=> col_q == $past(col_q) + COORD_W'(1) && row_q == $past(row_q))
		else $error("column counter did not advance by one");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !loc_ready |=> valid_s1 && $stable(loc_s1))
		else $error("stalled input stage lost or changed its beat");

endmodule

// ===== sv/lbt_format.sv =====
`timescale 1ns / 1ps
// Tiled index and texel formation into the output register.
module lbt_format
	import lbt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  loc_t       loc,
	input  logic       loc_valid,
	output logic       loc_ready,
	lbt_texel_if.source texels
);

	localparam int PROD_W = BLK_W + BCNT_W;

	logic               valid_s2;
	logic [INDEX_W-1:0] index_s2;
	logic [TEXEL_W-1:0] texel_s2;
	logic               last_s2;
	logic               load;
	logic [PROD_W-1:0]  row_base;
	logic [PROD_W-1:0]  block;

	assign loc_ready = !valid_s2 || texels.ready;
	assign load      = loc_valid && loc_ready;

	always_comb begin
		row_base = PROD_W'(loc.row_blk) * PROD_W'(cfg.blocks_x);
		block    = row_base + PROD_W'(loc.col_blk);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (loc_ready) begin
			valid_s2 <= loc_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			index_s2 <= {block[INDEX_W-5:0], loc.row_lo, loc.col_lo};
			texel_s2 <= to_texel(loc.pixel, cfg.format);
			last_s2  <= loc.last;
		end
	end

	assign texels.valid      = valid_s2;
	assign texels.tile_index = index_s2;
	assign texels.texel      = texel_s2;
	assign texels.frame_last = last_s2;

	a_s2_source: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 ##1 valid_s2 |-> $past(loc_valid))
		else $error("output beat appeared without a beat from the input stage");

endmodule

// ===== sv/linear_to_block_tiled_pixel_writer.sv =====
`timescale 1ns / 1ps
// Top level of the linear to 4x4 block tiled pixel writer.
//
// Source pixels arrive on the pixels channel in raster order, one beat per
// pixel. Each pixel inside the whole-block area leaves on the texels channel
// as one beat with its halfword index in the 4x4-block tiled buffer, its RGB565
// texel and a flag on the last kept pixel of the frame. Pixels right of or
// below the whole-block area are consumed and give no beat.
// The block takes one pixel per cycle while the receiver does not stall. A
// kept pixel's beat passes through the input register and then the output
// register, with the index multiply between them, before it is valid on the
// texels channel.
// When the receiver stalls, both registers hold. Once both are full, ready on
// the pixels channel follows ready on the texels channel in the same cycle,
// so every further stall also stalls the sender.
// Reset clears the column and row counters and both stages and loads a
// 640 by 480 frame in RGB565 mode. Registers are written through cfg_we,
// cfg_index and cfg_wdata; the user must do so only while no beat is in
// flight, which the block does not enforce; unknown-index writes are ignored.
module linear_to_block_tiled_pixel_writer
	import lbt_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	lbt_pixel_if.sink             pixels,
	lbt_texel_if.source           texels,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t cfg;
	loc_t loc;
	logic loc_valid;
	logic loc_ready;

	lbt_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	lbt_locate u_locate (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.pixels    (pixels),
		.loc       (loc),
		.loc_valid (loc_valid),
		.loc_ready (loc_ready)
	);

	lbt_format u_format (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.loc       (loc),
		.loc_valid (loc_valid),
		.loc_ready (loc_ready),
		.texels    (texels)
	);

endmodule
